// ===== src/tnns_pkg.sv =====
// shared types, widths and command codes for the tree node search block
package tnns_pkg;

  localparam int MaxNodes = 1024;
  localparam int IdxW     = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int CntW     = $clog2(MaxNodes + 1);

  localparam int CoordW   = 16;
  localparam int CostW    = 22;
  localparam int RegW     = 10;
  localparam int CfgIdxW  = 2;
  localparam int OutIdxW  = 10;
  localparam int OutCntW  = 11;
  localparam int SqW      = 2 * CoordW;
  localparam int DsqW     = SqW + 1;

  localparam int InFieldW  = 2 * CoordW + CostW;
  localparam int InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW = OutIdxW + 2 * CoordW + CostW + OutCntW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int InUserW   = 8;
  localparam int OutUserW  = 8;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdAppend  = 2'd1,
    CmdNearest = 2'd2,
    CmdParent  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRegionRadius  = 2'd0,
    RegNearestCutoff = 2'd1
  } reg_idx_e;

  localparam logic [RegW-1:0] RadiusReset = 10'd15;
  localparam logic [RegW-1:0] CutoffReset = 10'd1000;

  typedef struct packed {
    logic [CostW-1:0]  cost;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } node_t;

  localparam int NodeW = $bits(node_t);

endpackage

// ===== src/tree_node_nearest_search.sv =====
// top level: node table, scan sequencer and result register
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser: cmd; tdata: x, y, path cost
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser: found, full; tdata: node, count
//  cfg       | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// clear and append go from the idle state to the done state, then the result is registered
// a query makes one ram read per stored node (none on an empty table, which goes
// straight to done), then the read and distance pipeline drains before the result is loaded
// the table needs no clearing pass after reset, only the node count is reset
// a new request is taken once the sequencer is idle, even while the result waits
// the sequencer holds in its final state while m_axis is stalled
module tree_node_nearest_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: point_x [15:0], point_y [31:16], path_cost [53:32]
  input  logic [tnns_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [tnns_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: node_index [9:0], node_x [25:10], node_y [41:26], cost [63:42],
  //        node_count [74:64]
  output logic [tnns_pkg::OutDataW-1:0]    m_axis_tdata,
  // tuser: found [0], table_full [1]
  output logic [tnns_pkg::OutUserW-1:0]    m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [tnns_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tnns_pkg::RegW-1:0]        cfg_data_i
);
  import tnns_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StFlush = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef struct packed {
    logic            found;
    logic            full;
    logic [IdxW-1:0] idx;
    node_t           node;
  } res_t;

  state_e            state_q, state_d;
  logic [RegW-1:0]   radius_q, cutoff_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              parent_q, parent_d;
  logic [CoordW-1:0] px_q, py_q;
  logic [SqW-1:0]    lim_q, lim_d;
  logic [DsqW-1:0]   best_d_q, best_d_d;
  res_t              res_q, res_d;

  logic              out_vld_q;
  res_t              out_res_q;
  logic [CntW-1:0]   out_cnt_q;

  logic              accept;
  cmd_e              cmd;
  node_t             in_node;
  logic [CoordW-1:0] lim_base;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr;
  node_t             ram_rdata;
  logic              ram_vld_q;
  logic [IdxW-1:0]   ram_idx_q;

  logic              dist_vld, dist_busy;
  node_t             dist_node;
  logic [IdxW-1:0]   dist_idx;
  logic [DsqW-1:0]   dist_dsq;
  logic              take;

  assign cmd          = cmd_e'(s_axis_tuser[1:0]);
  assign in_node.x    = s_axis_tdata[CoordW-1:0];
  assign in_node.y    = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_node.cost = s_axis_tdata[InFieldW-1:2*CoordW];

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ram_waddr = count_q[IdxW-1:0];
  assign ram_re    = (state_q == StScan);

  tnns_ram #(
    .Width (NodeW),
    .Depth (MaxNodes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_node),
    .re_i    (ram_re),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  tnns_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ram_vld_q),
    .node_i (ram_rdata),
    .idx_i  (ram_idx_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .vld_o  (dist_vld),
    .node_o (dist_node),
    .idx_o  (dist_idx),
    .dsq_o  (dist_dsq),
    .busy_o (dist_busy)
  );

  // nearest keeps the running minimum, best parent the cheapest inside the radius
  always_comb begin
    if (parent_q) begin
      take = (dist_dsq < {1'b0, lim_q}) && (!res_q.found || dist_node.cost < res_q.node.cost);
    end else begin
      take = dist_dsq < best_d_q;
    end
  end

  assign lim_base = {radius_q, 6'b0};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    parent_d = parent_q;
    best_d_d = best_d_q;
    res_d    = res_q;
    ram_we   = 1'b0;
    lim_d    = lim_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_d = '0;
          ptr_d = '0;
          unique case (cmd) inside
            CmdClear: begin
              count_d = '0;
              state_d = StDone;
            end
            CmdAppend: begin
              if (count_q < CntW'(MaxNodes)) begin
                ram_we     = 1'b1;
                res_d.found = 1'b1;
                res_d.idx  = count_q[IdxW-1:0];
                res_d.node = in_node;
                count_d    = count_q + 1'b1;
              end else begin
                res_d.full = 1'b1;
              end
              state_d = StDone;
            end
            CmdNearest, CmdParent: begin
              parent_d = (cmd == CmdParent);
              if (cmd == CmdParent) begin
                lim_d = SqW'(lim_base) * SqW'(lim_base);
              end else begin
                lim_d = SqW'({cutoff_q, 6'b0}) * SqW'({cutoff_q, 6'b0});
              end
              best_d_d = {1'b0, lim_d};
              state_d  = (count_q == '0) ? StDone : StScan;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StScan: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == count_q - 1'b1) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!ram_vld_q && !dist_busy && !dist_vld) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (dist_vld && take) begin
      res_d.found = 1'b1;
      res_d.idx   = dist_idx;
      res_d.node  = dist_node;
      best_d_d    = dist_dsq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      radius_q  <= RadiusReset;
      cutoff_q  <= CutoffReset;
      ram_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ram_vld_q <= ram_re;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRegionRadius:  radius_q <= cfg_data_i;
          RegNearestCutoff: cutoff_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StDone && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    parent_q  <= parent_d;
    lim_q     <= lim_d;
    best_d_q  <= best_d_d;
    res_q     <= res_d;
    ram_idx_q <= ptr_q[IdxW-1:0];
    if (accept) begin
      px_q <= in_node.x;
      py_q <= in_node.y;
    end
    if (state_q == StDone && (!out_vld_q || m_axis_tready)) begin
      out_res_q <= res_q;
      out_cnt_q <= count_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = OutUserW'({out_res_q.full, out_res_q.found});
  assign m_axis_tdata  = OutDataW'({OutCntW'(out_cnt_q), out_res_q.node.cost,
                                    out_res_q.node.y, out_res_q.node.x,
                                    OutIdxW'(out_res_q.idx)});

endmodule

// ===== src/tnns_ram.sv =====
// generic single write port ram with registered read
module tnns_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tnns_dist.sv =====
// two stage squared distance pipeline between a stored node and the query point
module tnns_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  tnns_pkg::node_t               node_i,
  input  logic [tnns_pkg::IdxW-1:0]     idx_i,
  input  logic [tnns_pkg::CoordW-1:0]   px_i,
  input  logic [tnns_pkg::CoordW-1:0]   py_i,
  output logic                          vld_o,
  output tnns_pkg::node_t               node_o,
  output logic [tnns_pkg::IdxW-1:0]     idx_o,
  output logic [tnns_pkg::DsqW-1:0]     dsq_o,
  output logic                          busy_o
);
  import tnns_pkg::*;

  logic              vld_a_q, vld_b_q;
  node_t             node_a_q, node_b_q;
  logic [IdxW-1:0]   idx_a_q, idx_b_q;
  logic [CoordW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SqW-1:0]    sqx_q, sqy_q;

  always_comb begin
    dx_d = (node_i.x > px_i) ? (node_i.x - px_i) : (px_i - node_i.x);
    dy_d = (node_i.y > py_i) ? (node_i.y - py_i) : (py_i - node_i.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    node_a_q <= node_i;
    idx_a_q  <= idx_i;
    sqx_q    <= SqW'(dx_q) * SqW'(dx_q);
    sqy_q    <= SqW'(dy_q) * SqW'(dy_q);
    node_b_q <= node_a_q;
    idx_b_q  <= idx_a_q;
  end

  assign vld_o  = vld_b_q;
  assign node_o = node_b_q;
  assign idx_o  = idx_b_q;
  assign dsq_o  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign busy_o = vld_a_q | vld_b_q;

endmodule

// ===== src/tnns_chk.sv =====
// port level checks for the tree node search block, bound to the top level
module tnns_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tnns_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic [tnns_pkg::OutUserW-1:0]    m_axis_tuser
);
  import tnns_pkg::*;

  logic [OutIdxW-1:0] o_idx;
  logic [OutCntW-1:0] o_cnt;

  assign o_idx = m_axis_tdata[OutIdxW-1:0];
  assign o_cnt = m_axis_tdata[OutFieldW-1:OutFieldW-OutCntW];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a refused append never reports a node
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("found and table_full both set");

  // no node found means empty node fields
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[OutFieldW-OutCntW-1:0] == '0)
    else $error("node fields not zero without a node");

  // a reported node lies inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> OutCntW'(o_idx) < o_cnt
      && o_cnt <= OutCntW'(MaxNodes))
    else $error("node index outside the table");

endmodule

bind tree_node_nearest_search tnns_chk u_tnns_chk (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the tree node nearest search block
module testbench;
  import tnns_pkg::*;

  localparam int CycleLimit   = 3_000_000;
  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 93;
  localparam int Unit         = 64;  // one whole map unit in q10.6
  localparam int MaxCost      = (1 << CostW) - 1;
  localparam int MaxCoord     = (1 << CoordW) - 1;

  typedef struct {
    cmd_e              cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CostW-1:0]  cost;
    bit                drain_first;
  } request_t;

  typedef struct packed {
    logic               found;
    logic               full;
    logic [OutIdxW-1:0] idx;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [CostW-1:0]   cost;
    logic [OutCntW-1:0] count;
  } result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [InUserW-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [RegW-1:0]      cfg_data_i    = '0;

  // shadow of the node table and registers
  logic [CoordW-1:0] tree_x    [MaxNodes];
  logic [CoordW-1:0] tree_y    [MaxNodes];
  logic [CostW-1:0]  tree_cost [MaxNodes];
  int unsigned       tree_count = 0;
  logic [RegW-1:0]   cfg_radius = RadiusReset;
  logic [RegW-1:0]   cfg_cutoff = CutoffReset;

  request_t    request_fifo[$];
  result_t     results_due[$];
  request_t    req_on_bus;
  int unsigned req_accepted = 0;
  int unsigned resp_seen    = 0;
  int unsigned mismatches   = 0;
  int unsigned send_gap     = 0;
  int unsigned send_burst   = 0;
  int unsigned stall_left   = 0;
  int unsigned recv_burst   = 0;
  int unsigned cycle_cnt    = 0;

  // stimulus side view of the table, used to aim queries at stored nodes
  logic [CoordW-1:0] plan_x[$];
  logic [CoordW-1:0] plan_y[$];
  logic [RegW-1:0]   plan_radius = RadiusReset;
  logic [RegW-1:0]   plan_cutoff = CutoffReset;

  tree_node_nearest_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned dist_sq(input logic [CoordW-1:0] ax, ay, bx, by);
    longint unsigned dx, dy;
    dx = (ax > bx) ? longint'(ax) - longint'(bx) : longint'(bx) - longint'(ax);
    dy = (ay > by) ? longint'(ay) - longint'(by) : longint'(by) - longint'(ay);
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned reach_sq(input logic [RegW-1:0] whole);
    longint unsigned q;
    q = longint'(whole) * Unit;
    return q * q;
  endfunction

  // updates the shadow table and returns the result the request should give
  function automatic result_t predict_search(input request_t rq);
    result_t           res;
    longint unsigned   bound, d;
    logic [CostW-1:0]  cheapest;
    int unsigned       pick, i;
    res = '0;
    pick = 0;
    cheapest = '0;
    case (rq.cmd)
      CmdClear: begin
        tree_count = 0;
      end
      CmdAppend: begin
        if (tree_count < MaxNodes) begin
          tree_x[tree_count] = rq.x;
          tree_y[tree_count] = rq.y;
          tree_cost[tree_count] = rq.cost;
          pick = tree_count;
          tree_count++;
          res.found = 1'b1;
        end else begin
          res.full = 1'b1;
        end
      end
      CmdNearest: begin
        bound = reach_sq(cfg_cutoff);
        for (i = 0; i < tree_count; i++) begin
          d = dist_sq(tree_x[i], tree_y[i], rq.x, rq.y);
          if (d < bound) begin
            bound = d;
            pick = i;
            res.found = 1'b1;
          end
        end
      end
      default: begin
        bound = reach_sq(cfg_radius);
        for (i = 0; i < tree_count; i++) begin
          d = dist_sq(tree_x[i], tree_y[i], rq.x, rq.y);
          if (d < bound && (!res.found || tree_cost[i] < cheapest)) begin
            cheapest = tree_cost[i];
            pick = i;
            res.found = 1'b1;
          end
        end
      end
    endcase
    if (res.found) begin
      res.idx = pick[OutIdxW-1:0];
      res.x = tree_x[pick];
      res.y = tree_y[pick];
      res.cost = tree_cost[pick];
    end
    res.count = tree_count[OutCntW-1:0];
    return res;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("found=%0d full=%0d index=%0d x=%h y=%h cost=%h count=%0d",
                     r.found, r.full, r.idx, r.x, r.y, r.cost, r.count);
  endfunction

  // mostly short idles, a few long ones, and now and then a run with none
  function automatic int unsigned idle_len(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CoordW-1:0] any_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CoordW'(MaxCoord);
    return CoordW'($urandom_range(0, MaxCoord));
  endfunction

  function automatic logic [CoordW-1:0] nudge(input logic [CoordW-1:0] base,
                                              input int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > MaxCoord) v = MaxCoord;
    return CoordW'(v);
  endfunction

  function automatic logic [CostW-1:0] any_cost();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return CostW'($urandom_range(0, 3) * 100);  // frequent ties
    if (r < 35) return CostW'(MaxCost);
    return CostW'($urandom_range(0, MaxCost));
  endfunction

  task automatic push_req(input cmd_e c, input logic [CoordW-1:0] x, y,
                          input logic [CostW-1:0] cost, input bit drain = 1'b0);
    request_t rq;
    rq.cmd = c;
    rq.x = x;
    rq.y = y;
    rq.cost = cost;
    rq.drain_first = drain;
    request_fifo.insert(request_fifo.size(), rq);
    if (c == CmdClear) begin
      plan_x.delete();
      plan_y.delete();
    end else if (c == CmdAppend && plan_x.size() < MaxNodes) begin
      plan_x.insert(plan_x.size(), x);
      plan_y.insert(plan_y.size(), y);
    end
  endtask

  task automatic add_query(input cmd_e c);
    int unsigned reach, k, r;
    logic [CoordW-1:0] bx, by, qx;
    reach = ((c == CmdParent) ? int'(plan_radius) : int'(plan_cutoff)) * Unit;
    if (plan_x.size() == 0 || $urandom_range(0, 3) == 0) begin
      push_req(c, any_coord(), any_coord(), any_cost());
    end else begin
      k = $urandom_range(0, plan_x.size() - 1);
      bx = plan_x[k];
      by = plan_y[k];
      r = $urandom_range(0, 9);
      if (r == 0) begin
        push_req(c, bx, by, any_cost());
      end else if (r == 1) begin
        // exactly on the limit along one axis
        if (int'(bx) + reach <= MaxCoord) qx = CoordW'(int'(bx) + reach);
        else if (int'(bx) >= reach) qx = CoordW'(int'(bx) - reach);
        else qx = nudge(bx, reach);
        push_req(c, qx, by, any_cost());
      end else begin
        push_req(c, nudge(bx, reach * 3 / 4 + 1), nudge(by, reach * 3 / 4 + 1),
                 any_cost());
      end
    end
  endtask

  task automatic add_random_request();
    int unsigned r, k;
    r = $urandom_range(0, 99);
    if (r < 3 || (plan_x.size() >= 48 && r < 20)) begin
      push_req(CmdClear, any_coord(), any_coord(), any_cost());
    end else if (r < 40) begin
      if (plan_x.size() != 0 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, plan_x.size() - 1);
        push_req(CmdAppend, nudge(plan_x[k], plan_radius * Unit / 2 + 1),
                 nudge(plan_y[k], plan_radius * Unit / 2 + 1), any_cost());
      end else begin
        push_req(CmdAppend, any_coord(), any_coord(), any_cost());
      end
    end else if (r < 70) begin
      add_query(CmdNearest);
    end else begin
      add_query(CmdParent);
    end
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == RegRegionRadius) cfg_radius = val;
    else if (idx == RegNearestCutoff) cfg_cutoff = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic begin_phase(input logic [RegW-1:0] radius, cutoff,
                             input bit touch_unmapped = 1'b0);
    int i;
    set_reg(RegRegionRadius, radius);
    set_reg(RegNearestCutoff, cutoff);
    if (touch_unmapped) begin
      for (i = int'(RegNearestCutoff) + 1; i < (1 << CfgIdxW); i++)
        set_reg(CfgIdxW'(i), RegW'($urandom_range(0, (1 << RegW) - 1)));
    end
    plan_radius = radius;
    plan_cutoff = cutoff;
    @(negedge clk_i);
  endtask

  // block is idle once nothing is queued or on the bus and every result is back
  task automatic settle();
    while (!(request_fifo.size() == 0 && !s_axis_tvalid && req_accepted == resp_seen))
      @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    logic took;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        results_due.insert(results_due.size(), predict_search(req_on_bus));
        req_accepted <= req_accepted + 1;
      end
      if (!s_axis_tvalid || took) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (request_fifo.size() != 0 &&
                     !(request_fifo[0].drain_first && req_accepted + took != resp_seen)) begin
          req_on_bus = request_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= InDataW'({req_on_bus.cost, req_on_bus.y, req_on_bus.x});
          s_axis_tuser <= InUserW'(req_on_bus.cmd);
          send_gap <= idle_len(send_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t     got, want;
    int unsigned len;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        resp_seen <= resp_seen + 1;
        got.found = m_axis_tuser[0];
        got.full = m_axis_tuser[1];
        {got.count, got.cost, got.y, got.x, got.idx} = m_axis_tdata[OutFieldW-1:0];
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at request %0d\n  expected %s\n  actual   %s",
                       resp_seen, show(want), show(got));
          end
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        len = idle_len(recv_burst);
        m_axis_tready <= (len == 0);
        if (len != 0) stall_left <= len - 1;
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("FAIL tree_node_nearest_search");
    $finish;
  end

  initial begin : run_phases
    int ph, n;
    logic [RegW-1:0] rad, cut;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed requests at the reset settings (radius 15, cutoff 1000)
    push_req(CmdNearest, 100, 200, 0);
    push_req(CmdParent, 100, 200, 0);
    push_req(CmdAppend, 0, 0, 0);
    push_req(CmdAppend, MaxCoord, MaxCoord, MaxCost);
    push_req(CmdAppend, 10 * Unit, 10 * Unit, 300);
    push_req(CmdAppend, 10 * Unit, 10 * Unit, 300);
    push_req(CmdAppend, 25 * Unit, 10 * Unit, 5);     // exactly on the radius
    push_req(CmdAppend, 10 * Unit, 24 * Unit, 300);   // just inside
    push_req(CmdNearest, 10 * Unit, 10 * Unit, 0, 1'b1);
    push_req(CmdParent, 10 * Unit, 10 * Unit, 0);
    push_req(CmdAppend, 10 * Unit + 1, 10 * Unit, 100);
    push_req(CmdParent, 10 * Unit, 10 * Unit, 0);
    push_req(CmdNearest, MaxCoord, MaxCoord, MaxCost);
    push_req(CmdParent, MaxCoord, MaxCoord, MaxCost);
    push_req(CmdNearest, 0, 0, 0);
    push_req(CmdNearest, 40 * Unit, 0, 0);
    push_req(CmdParent, 0, MaxCoord, 0);
    push_req(CmdClear, MaxCoord, MaxCoord, MaxCost);
    push_req(CmdNearest, 0, 0, 0);
    push_req(CmdAppend, 1, 2, 3);
    push_req(CmdParent, 1, 2, 0);
    settle();

    for (ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin rad = 0; cut = (1 << RegW) - 1; end
        1: begin rad = (1 << RegW) - 1; cut = 0; end
        2: begin
          rad = RegW'($urandom_range(1, 40));
          cut = RegW'($urandom_range(1, 100));
        end
        3: begin
          rad = RegW'($urandom_range(1, 40));
          cut = RegW'($urandom_range(100, 1023));
        end
        4: begin rad = 1; cut = 1; end
        default: begin
          rad = RegW'($urandom_range(0, 1023));
          cut = RegW'($urandom_range(0, 1023));
        end
      endcase
      begin_phase(rad, cut, ph == 2);
      for (n = 0; n < PhaseItems; n++) begin
        add_random_request();
        if (ph == 0 && n == PhaseItems / 2)
          request_fifo[request_fifo.size() - 1].drain_first = 1'b1;
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS tree_node_nearest_search");
    end else begin
      $display("FAIL tree_node_nearest_search");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tnns_pkg.sv
src/tnns_ram.sv
src/tnns_dist.sv
src/tree_node_nearest_search.sv
src/tnns_chk.sv
test/testbench.sv
